FILE: rtl/core/wac_pkg.sv
`default_nettype none
package wac_pkg;

  localparam int MAX_NODES     = 1024;
  localparam int ALPHABET_SIZE = 26;
  localparam int NODE_W        = $clog2(MAX_NODES);
  localparam int CNT_W         = NODE_W + 1;
  localparam int LET_W         = 5;
  localparam int GADDR_W       = $clog2(MAX_NODES * ALPHABET_SIZE);
  localparam int WEIGHT_W      = 16;
  localparam int PW_W          = 8;
  localparam int OP_W          = 3;
  localparam int STEP_W        = 5;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_END    = 3'd1;
  localparam logic [OP_W-1:0] OP_BUILD  = 3'd2;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_NOBUILD = 2'd2;

  localparam logic [STEP_W-1:0] S_IDLE   = 5'd0;
  localparam logic [STEP_W-1:0] S_DISP   = 5'd1;
  localparam logic [STEP_W-1:0] S_AP_RDG = 5'd2;
  localparam logic [STEP_W-1:0] S_AP_RDP = 5'd3;
  localparam logic [STEP_W-1:0] S_AP_DEC = 5'd4;
  localparam logic [STEP_W-1:0] S_END    = 5'd5;
  localparam logic [STEP_W-1:0] S_LK_RDG = 5'd6;
  localparam logic [STEP_W-1:0] S_LK_GET = 5'd7;
  localparam logic [STEP_W-1:0] S_B_INIT = 5'd8;
  localparam logic [STEP_W-1:0] S_B_POP  = 5'd9;
  localparam logic [STEP_W-1:0] S_B_T    = 5'd10;
  localparam logic [STEP_W-1:0] S_B_FT   = 5'd11;
  localparam logic [STEP_W-1:0] S_B_RDG  = 5'd12;
  localparam logic [STEP_W-1:0] S_B_RDP  = 5'd13;
  localparam logic [STEP_W-1:0] S_B_DEC  = 5'd14;
  localparam logic [STEP_W-1:0] S_B_W1   = 5'd15;
  localparam logic [STEP_W-1:0] S_B_W2   = 5'd16;
  localparam logic [STEP_W-1:0] S_RDW    = 5'd17;
  localparam logic [STEP_W-1:0] S_OUT    = 5'd18;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              load;
  } wac_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            built;
    logic            ap_ok;
    logic            lk_ok;
    logic            queue_empty;
    logic            last_letter;
    logic            child;
  } wac_stat_t;

  function automatic logic [GADDR_W-1:0] row_base(input logic [NODE_W-1:0] node);
    row_base = GADDR_W'(node) * GADDR_W'(ALPHABET_SIZE);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/wac_ctrl.sv
`default_nettype none
module wac_ctrl import wac_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire wac_stat_t stat,
  output wac_cmd_t       cmd,
  output logic           busy
);

  logic [STEP_W-1:0] state;
  logic [STEP_W-1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_DISP;
      S_DISP: begin
        unique case (stat.op)
          OP_APPEND: state_next = stat.ap_ok ? S_AP_RDG : S_RDW;
          OP_END:    state_next = S_END;
          OP_BUILD:  state_next = stat.built ? S_RDW : S_B_INIT;
          OP_LOOKUP: begin
            if (!stat.built) state_next = S_OUT;
            else state_next = stat.lk_ok ? S_LK_RDG : S_RDW;
          end
          OP_CLEAR:  state_next = S_OUT;
          default:   state_next = S_RDW;
        endcase
      end
      S_AP_RDG: state_next = S_AP_RDP;
      S_AP_RDP: state_next = S_AP_DEC;
      S_AP_DEC: state_next = S_RDW;
      S_END:    state_next = S_RDW;
      S_LK_RDG: state_next = S_LK_GET;
      S_LK_GET: state_next = S_RDW;
      S_B_INIT: state_next = S_B_POP;
      S_B_POP:  state_next = stat.queue_empty ? S_RDW : S_B_T;
      S_B_T:    state_next = S_B_FT;
      S_B_FT:   state_next = S_B_RDG;
      S_B_RDG:  state_next = S_B_RDP;
      S_B_RDP:  state_next = S_B_DEC;
      S_B_DEC: begin
        if (stat.child) state_next = S_B_W1;
        else state_next = stat.last_letter ? S_B_POP : S_B_RDG;
      end
      S_B_W1:   state_next = S_B_W2;
      S_B_W2:   state_next = stat.last_letter ? S_B_POP : S_B_RDG;
      S_RDW:    state_next = S_OUT;
      S_OUT:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign busy     = (state != S_IDLE);
  assign cmd.step = state;
  assign cmd.load = (state == S_IDLE) && start;

endmodule
`default_nettype wire

FILE: rtl/core/wac_dpath.sv
`default_nettype none
module wac_dpath import wac_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire wac_cmd_t            cmd,
  input  wire logic [OP_W-1:0]     op,
  input  wire logic [LET_W-1:0]    letter,
  input  wire logic [PW_W-1:0]     pattern_weight,
  input  wire logic [NODE_W-1:0]   query_state,
  output wac_stat_t                stat,
  output logic                     done,
  output logic [NODE_W-1:0]        next_state,
  output logic [WEIGHT_W-1:0]      state_weight,
  output logic [1:0]               status
);

  // Tables. Trie edges are trusted before the build only when the target
  // node records this edge as its own parent edge, so no row clearing is needed.
  logic [NODE_W-1:0]   gmem [MAX_NODES*ALPHABET_SIZE];
  logic [NODE_W-1:0]   pmem [MAX_NODES];
  logic [LET_W-1:0]    lmem [MAX_NODES];
  logic [NODE_W-1:0]   fmem [MAX_NODES];
  logic [WEIGHT_W-1:0] wmem [MAX_NODES];
  logic [NODE_W-1:0]   qmem [MAX_NODES];

  logic [NODE_W-1:0]   gq, pq, fq, qq;
  logic [LET_W-1:0]    lq;
  logic [WEIGHT_W-1:0] wq;

  logic [OP_W-1:0]     op_r;
  logic [LET_W-1:0]    letter_r;
  logic [PW_W-1:0]     pw_r;
  logic [NODE_W-1:0]   qs_r;

  logic [NODE_W-1:0]   ins;
  logic [CNT_W-1:0]    nc;
  logic                built;
  logic [WEIGHT_W-1:0] root_w;
  logic [CNT_W-1:0]    head, tail;
  logic [NODE_W-1:0]   t, c, f, ns;
  logic [GADDR_W-1:0]  tbase, ftbase;
  logic [LET_W-1:0]    i;
  logic [WEIGHT_W-1:0] wc;
  logic [1:0]          stat_r;
  logic                zero_w;

  logic [GADDR_W-1:0]  ap_addr, lk_addr, t_addr, ft_addr;
  logic                ap_valid, child, letter_ok;
  logic [WEIGHT_W:0]   wsum;
  logic [WEIGHT_W-1:0] wf;

  logic                g_we, p_we, f_we, w_we, q_we;
  logic [GADDR_W-1:0]  g_waddr, g_raddr;
  logic [NODE_W-1:0]   g_wdata, p_raddr, f_waddr, f_wdata, f_raddr;
  logic [NODE_W-1:0]   w_waddr, w_raddr, q_waddr, q_wdata, q_raddr;
  logic [WEIGHT_W-1:0] w_wdata;

  assign ap_addr   = row_base(ins) + GADDR_W'(letter_r);
  assign lk_addr   = row_base(qs_r) + GADDR_W'(letter_r);
  assign t_addr    = tbase + GADDR_W'(i);
  assign ft_addr   = ftbase + GADDR_W'(i);
  assign letter_ok = letter_r < LET_W'(ALPHABET_SIZE);
  assign ap_valid  = (c != '0) && ({1'b0, c} < nc) && (pq == ins) && (lq == letter_r);
  assign child     = (c != '0) && ({1'b0, c} < nc) && (pq == t) && (lq == i);
  assign wf        = (f == '0) ? root_w : wq;
  assign wsum      = {1'b0, wc} + {1'b0, wf};

  assign stat.op          = op_r;
  assign stat.built       = built;
  assign stat.ap_ok       = !built && letter_ok;
  assign stat.lk_ok       = letter_ok && ({1'b0, qs_r} < nc);
  assign stat.queue_empty = (head == tail);
  assign stat.last_letter = (i == LET_W'(ALPHABET_SIZE - 1));
  assign stat.child       = child;

  always_comb begin
    g_we = 1'b0; g_waddr = ap_addr; g_wdata = nc[NODE_W-1:0];
    g_raddr = t_addr;
    p_we = 1'b0; p_raddr = gq;
    f_we = 1'b0; f_waddr = c; f_wdata = (t == '0) ? '0 : gq; f_raddr = qq;
    w_we = 1'b0; w_waddr = nc[NODE_W-1:0]; w_wdata = '0; w_raddr = ns;
    q_we = 1'b0; q_waddr = tail[NODE_W-1:0]; q_wdata = c; q_raddr = head[NODE_W-1:0];
    unique case (cmd.step)
      S_AP_RDG: g_raddr = ap_addr;
      S_AP_DEC: begin
        if (!ap_valid && (nc < CNT_W'(MAX_NODES))) begin
          g_we = 1'b1;
          p_we = 1'b1;
          w_we = 1'b1;
        end
      end
      S_END: begin
        if (!built && ins != '0) begin
          w_we    = 1'b1;
          w_waddr = ins;
          w_wdata = WEIGHT_W'(pw_r);
        end
      end
      S_LK_RDG: g_raddr = lk_addr;
      S_B_INIT: begin
        q_we = 1'b1; q_waddr = '0; q_wdata = '0;
        f_we = 1'b1; f_waddr = '0; f_wdata = '0;
      end
      S_B_RDP:  g_raddr = ft_addr;
      S_B_DEC: begin
        w_raddr = c;
        if (child) begin
          f_we = 1'b1;
        end else begin
          g_we    = 1'b1;
          g_waddr = t_addr;
          g_wdata = (t == '0) ? '0 : gq;
        end
      end
      S_B_W1:   w_raddr = f;
      S_B_W2: begin
        w_we    = 1'b1;
        w_waddr = c;
        w_wdata = wsum[WEIGHT_W] ? '1 : wsum[WEIGHT_W-1:0];
        q_we    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (g_we) gmem[g_waddr] <= g_wdata;
    gq <= gmem[g_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[nc[NODE_W-1:0]] <= ins;
      lmem[nc[NODE_W-1:0]] <= letter_r;
    end
    pq <= pmem[p_raddr];
    lq <= lmem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (f_we) fmem[f_waddr] <= f_wdata;
    fq <= fmem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    wq <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) qmem[q_waddr] <= q_wdata;
    qq <= qmem[q_raddr];
  end

  // Payload and work registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op;
      letter_r <= letter;
      pw_r     <= pattern_weight;
      qs_r     <= query_state;
    end
    unique case (cmd.step)
      S_DISP: begin
        if (op_r == OP_LOOKUP && !built) begin
          ns     <= '0;
          zero_w <= 1'b1;
          stat_r <= STAT_NOBUILD;
        end else if (op_r == OP_CLEAR) begin
          ns     <= '0;
          zero_w <= 1'b1;
          stat_r <= STAT_OK;
        end else begin
          ns     <= (op_r == OP_BUILD || op_r == OP_LOOKUP) ? '0 : ins;
          zero_w <= 1'b0;
          stat_r <= STAT_OK;
        end
      end
      S_AP_RDP: c <= gq;
      S_AP_DEC: begin
        if (ap_valid) ns <= c;
        else if (nc < CNT_W'(MAX_NODES)) ns <= nc[NODE_W-1:0];
        else stat_r <= STAT_FULL;
      end
      S_LK_GET: ns <= gq;
      S_B_INIT: begin
        head <= '0;
        tail <= CNT_W'(1);
      end
      S_B_POP:  head <= head + CNT_W'(1);
      S_B_T: begin
        t     <= qq;
        tbase <= row_base(qq);
        i     <= '0;
      end
      S_B_FT:   ftbase <= row_base(fq);
      S_B_RDP:  c <= gq;
      S_B_DEC: begin
        f <= (t == '0) ? '0 : gq;
        if (!child) i <= i + LET_W'(1);
      end
      S_B_W1:   wc <= wq;
      S_B_W2: begin
        tail <= tail + CNT_W'(1);
        i    <= i + LET_W'(1);
      end
      default: ;
    endcase
  end

  // Control state of the trie.
  always_ff @(posedge clk) begin
    if (rst) begin
      ins    <= '0;
      nc     <= CNT_W'(1);
      built  <= 1'b0;
      root_w <= '0;
    end else begin
      unique case (cmd.step)
        S_DISP: begin
          if (op_r == OP_CLEAR) begin
            ins    <= '0;
            nc     <= CNT_W'(1);
            built  <= 1'b0;
            root_w <= '0;
          end
        end
        S_AP_DEC: begin
          if (ap_valid) begin
            ins <= c;
          end else if (nc < CNT_W'(MAX_NODES)) begin
            ins <= nc[NODE_W-1:0];
            nc  <= nc + CNT_W'(1);
          end
        end
        S_END: begin
          if (!built) begin
            if (ins == '0) root_w <= WEIGHT_W'(pw_r);
            ins <= '0;
          end
        end
        S_B_POP:  if (head == tail) built <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.step == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == S_OUT) begin
      next_state   <= ns;
      state_weight <= zero_w ? '0 : ((ns == '0) ? root_w : wq);
      status       <= stat_r;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/weighted_aho_corasick_builder.sv
`default_nettype none
// Weighted Aho-Corasick automaton builder, 26-letter alphabet, 1024 nodes.
// A command word (op, letter, pattern_weight, query_state) is taken at a
// rising edge with start high and busy low. Exactly one result word
// (next_state, state_weight, status) follows, shown for one cycle with done
// high; the receiver cannot stall, so it must take the word in that cycle.
// A new command may be given in the cycle where done is high.
// The build walks the trie breadth first with one read port and one write
// port per table. One command is processed at a time.
// Tables need no clearing pass: reset and clear only restore the insert
// node, the node count, the built flag and the root weight, and the block
// takes commands in the cycle after reset is released.
module weighted_aho_corasick_builder import wac_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [OP_W-1:0]     op,
  input  wire logic [LET_W-1:0]    letter,
  input  wire logic [PW_W-1:0]     pattern_weight,
  input  wire logic [NODE_W-1:0]   query_state,
  output logic                     done,
  output logic [NODE_W-1:0]        next_state,
  output logic [WEIGHT_W-1:0]      state_weight,
  output logic [1:0]               status
);

  wac_cmd_t  cmd;
  wac_stat_t stat;

  wac_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  wac_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .op             (op),
    .letter         (letter),
    .pattern_weight (pattern_weight),
    .query_state    (query_state),
    .stat           (stat),
    .done           (done),
    .next_state     (next_state),
    .state_weight   (state_weight),
    .status         (status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted word did not raise busy");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while still busy");

  a_nobuild_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_NOBUILD |-> next_state == '0 && state_weight == '0)
    else $error("lookup before build returned nonzero data");

endmodule
`default_nettype wire
